[rtl/dmx_tx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dmx_tx_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_BREAK_TIME     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARK_AFTER_BRK = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TIME       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_TIME      = 8'd3;
    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic [15:0] BREAK_TIME_RST = 16'd176;
    localparam logic [15:0] MAB_TIME_RST   = 16'd12;
    localparam logic [7:0]  BIT_TIME_RST   = 8'd4;
    localparam logic [7:0]  STOP_TIME_RST  = 8'd8;

    // data bits still to send after the first one of a frame
    localparam logic [2:0] DATA_BITS_AFTER_FIRST = 3'd7;

    // start code sent after mark-after-break
    localparam logic [7:0] START_CODE = 8'h00;

    // item action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_OFFER = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BREAK = 3'd1,
        PH_MAB   = 3'd2,
        PH_START = 3'd3,
        PH_DATA  = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] slot_value;
        logic       new_packet;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic byte_taken;
        logic busy_res;
    } out_item_t;

    // a duration of zero counts as one tick
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        at_least_one = (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

[rtl/dmx512_frame_transmitter.sv]
`timescale 1ns / 1ps
`default_nettype none

// DMX512 line transmitter, advanced by input items.
// Input channel (in_valid / in_stall / in_data): each item is either a
// microsecond tick (action 0) or an offer of a slot byte (action 1).
// An offer is latched into a one-byte holding register only when it is
// empty; a byte flagged new_packet is preceded by break, mark-after-break
// and a zero start-code frame. Frames are start bit, eight data bits lsb
// first and a high stop time.
// Output channel (out_valid / out_stall / out_data): exactly one result
// item per input item, carrying the line level, whether the offer was
// taken, and whether a break, mark or frame is in progress.
// The result is registered at the accepting edge
// and is offered in the cycle after it.
// Throughput is one item per cycle when not stalled; all state updates happen in the single
// logic stage ahead of the result register.
// While the output register holds an untaken result and out_stall is high,
// in_stall is raised and no item is accepted.
// Reset clears the line to idle high, empties the holding register and
// loads the default break, mark, bit and stop times.
// Timing registers are written through wr_en / wr_index / wr_data.
module dmx512_frame_transmitter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire dmx_tx_pkg::in_item_t                in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output dmx_tx_pkg::out_item_t                    out_data,
    input  wire logic                                wr_en,
    input  wire logic [dmx_tx_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  wire logic [dmx_tx_pkg::CFG_DATA_W-1:0]   wr_data
);
    import dmx_tx_pkg::*;

    // configuration
    logic [15:0] break_time_reg;
    logic [15:0] mab_time_reg;
    logic [7:0]  bit_time_reg;
    logic [7:0]  stop_time_reg;

    // transmitter state
    phase_t      phase_reg,      phase_next;
    logic [15:0] ticks_left_reg, ticks_left_next;
    logic [2:0]  bits_left_reg,  bits_left_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  held_byte_reg,  held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic        held_pkt_reg,   held_pkt_next;
    logic        line_out_reg,   line_out_next;
    logic        taken;

    // result register
    logic        out_valid_reg,  out_valid_next;
    out_item_t   out_data_reg,   out_data_next;

    logic        in_fire;
    logic        running;
    logic [15:0] bit_dur;
    logic [15:0] stop_dur;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign running  = (phase_reg != PH_IDLE);
    assign bit_dur  = at_least_one({8'd0, bit_time_reg});
    assign stop_dur = at_least_one({8'd0, stop_time_reg});

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_time_reg <= BREAK_TIME_RST;
            mab_time_reg   <= MAB_TIME_RST;
            bit_time_reg   <= BIT_TIME_RST;
            stop_time_reg  <= STOP_TIME_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_BREAK_TIME:     break_time_reg <= wr_data;
                CFG_MARK_AFTER_BRK: mab_time_reg   <= wr_data;
                CFG_BIT_TIME:       bit_time_reg   <= wr_data[7:0];
                CFG_STOP_TIME:      stop_time_reg  <= wr_data[7:0];
                default:            ;
            endcase
        end
    end

    // next state: holding register and line sequencer
    always_comb
    begin
        phase_next      = phase_reg;
        ticks_left_next = ticks_left_reg;
        bits_left_next  = bits_left_reg;
        shift_byte_next = shift_byte_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_pkt_next   = held_pkt_reg;
        line_out_next   = line_out_reg;
        taken           = 1'b0;

        if (in_fire)
        begin
            if (in_data.action == ACT_OFFER)
            begin
                if (!held_valid_reg)
                begin
                    held_byte_next  = in_data.slot_value;
                    held_pkt_next   = in_data.new_packet;
                    held_valid_next = 1'b1;
                    taken           = 1'b1;
                end
            end
            else if (running && ticks_left_reg > 16'd1)
            begin
                ticks_left_next = ticks_left_reg - 16'd1;
            end
            else
            begin
                case (phase_reg)
                    PH_BREAK:
                    begin
                        phase_next      = PH_MAB;
                        line_out_next   = 1'b1;
                        ticks_left_next = at_least_one(mab_time_reg);
                    end
                    PH_MAB:
                    begin
                        shift_byte_next = START_CODE;
                        phase_next      = PH_START;
                        line_out_next   = 1'b0;
                        ticks_left_next = bit_dur;
                    end
                    PH_START:
                    begin
                        bits_left_next  = DATA_BITS_AFTER_FIRST;
                        line_out_next   = shift_byte_reg[0];
                        shift_byte_next = shift_byte_reg >> 1;
                        phase_next      = PH_DATA;
                        ticks_left_next = bit_dur;
                    end
                    PH_DATA:
                    begin
                        if (bits_left_reg != 3'd0)
                        begin
                            bits_left_next  = bits_left_reg - 3'd1;
                            line_out_next   = shift_byte_reg[0];
                            shift_byte_next = shift_byte_reg >> 1;
                            phase_next      = PH_DATA;
                            ticks_left_next = bit_dur;
                        end
                        else
                        begin
                            phase_next      = PH_STOP;
                            line_out_next   = 1'b1;
                            ticks_left_next = stop_dur;
                        end
                    end
                    default:
                    begin
                        // stop finished or idle: start next byte, or the break before it, if any
                        if (held_valid_reg)
                        begin
                            if (held_pkt_reg)
                            begin
                                held_pkt_next   = 1'b0;
                                phase_next      = PH_BREAK;
                                line_out_next   = 1'b0;
                                ticks_left_next = at_least_one(break_time_reg);
                            end
                            else
                            begin
                                shift_byte_next = held_byte_reg;
                                held_valid_next = 1'b0;
                                phase_next      = PH_START;
                                line_out_next   = 1'b0;
                                ticks_left_next = bit_dur;
                            end
                        end
                        else
                        begin
                            phase_next      = PH_IDLE;
                            line_out_next   = 1'b1;
                            ticks_left_next = 16'd0;
                        end
                    end
                endcase
            end
        end
    end

    // result item and output handshake
    always_comb
    begin
        out_data_next.line_level = line_out_next;
        out_data_next.byte_taken = taken;
        out_data_next.busy_res   = (phase_next != PH_IDLE);

        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            ticks_left_reg <= 16'd0;
            bits_left_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            held_pkt_reg   <= 1'b0;
            line_out_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            ticks_left_reg <= ticks_left_next;
            bits_left_reg  <= bits_left_next;
            shift_byte_reg <= shift_byte_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_pkt_reg   <= held_pkt_next;
            line_out_reg   <= line_out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    // an accepted offer into an empty holding register fills it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.action == ACT_OFFER && !held_valid_reg |=> held_valid_reg)
        else $error("offer taken but holding register not filled");

    // any running period has at least one tick left
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> ticks_left_reg != 16'd0)
        else $error("running period with zero tick count");

    // idle line is high
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> line_out_reg)
        else $error("line low while idle");

    // a packet flag never outlives its held byte
    assert property (@(posedge clk) disable iff (!rst_n)
        held_pkt_reg |-> held_valid_reg)
        else $error("packet flag set with empty holding register");

    // result reflects the line state after its item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg && out_data_reg.line_level == line_out_reg)
        else $error("result line level does not match line state");

endmodule

`default_nettype wire
